FILE: rtl/pfs_pkg.sv
// shared types and constants for the potential field force sum block
`default_nettype none
package pfs_pkg;

	typedef struct packed {
		logic signed [15:0] sample_angle_0;
		logic signed [15:0] sample_angle_1;
		logic               attractive;
		logic               last_sample;
	} pfs_in_t;

	typedef struct packed {
		logic [31:0]        force_magnitude;
		logic signed [31:0] direction_0;
		logic signed [31:0] direction_1;
		logic               normalized;
		logic               zero_distance_seen;
		logic               saturated;
	} pfs_out_t;

	localparam logic [1:0] REG_CUR0   = 2'd0;
	localparam logic [1:0] REG_CUR1   = 2'd1;
	localparam logic [1:0] REG_THRESH = 2'd2;

	localparam logic signed [21:0] PI_Q16      = 22'sd205887;
	localparam logic signed [21:0] TWO_PI_Q16  = 22'sd411774;
	localparam logic signed [21:0] FOUR_PI_Q16 = 22'sd823548;
	localparam logic signed [21:0] HALF_PI_Q16 = 22'sd102944;
	localparam logic signed [19:0] CORDIC_GAIN = 20'sd39797;

	function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
		logic signed [19:0] r;
		case (i)
			4'd0:    r = 20'sd51472;
			4'd1:    r = 20'sd30385;
			4'd2:    r = 20'sd16055;
			4'd3:    r = 20'sd8150;
			4'd4:    r = 20'sd4091;
			4'd5:    r = 20'sd2047;
			4'd6:    r = 20'sd1024;
			4'd7:    r = 20'sd512;
			4'd8:    r = 20'sd256;
			4'd9:    r = 20'sd128;
			4'd10:   r = 20'sd64;
			4'd11:   r = 20'sd32;
			4'd12:   r = 20'sd16;
			4'd13:   r = 20'sd8;
			4'd14:   r = 20'sd4;
			default: r = 20'sd2;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/potential_field_force_sum_top.sv
// potential field force sum: cordic, isqrt, divider and multiplier shared under one sequencer
// per joint, each sample runs trig and distance (two 16-step cordic runs, one 32-step square
// root) and then, unless the distance is zero, a 32-step force divide per joint unless it saturates
// the last sample adds the 32-step norm root and, when normalized, two 15-step direction divides
// one sample in flight at a time; in_stall is high from the transfer until the sequencer is back
// arst_n clears sequencer, batch sums and flags; registers reset to 0, 0, 1
`default_nettype none
module potential_field_force_sum_top import pfs_pkg::*; #(
	parameter int DIMENSIONS = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire pfs_in_t     in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output pfs_out_t         out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int JOINTS = (DIMENSIONS < 2) ? 1 : 2;

	typedef enum logic [4:0] {
		S_IDLE, S_ANG, S_RED, S_CORD, S_SQX, S_SQY, S_SQRT, S_DCHK, S_D2,
		S_FV, S_DIV, S_ACC, S_FIN, S_SQ0, S_SQ1, S_NORM, S_OUT
	} state_t;

	typedef enum logic [1:0] {DK_FORCE, DK_DIR0, DK_DIR1} div_kind_t;

	state_t state_q;
	div_kind_t div_kind_q;

	logic signed [15:0] cur0_q, cur1_q;
	logic [15:0] thresh_q;
	logic signed [15:0] smp0_q, smp1_q;
	logic attr_q, last_q;
	logic j_q;
	logic which_q;
	logic sqrt_final_q;

	logic signed [17:0] t1_q, t2_q;
	logic signed [19:0] x_q, y_q, z_q, c1_q, s1_q;
	logic neg_q;
	logic [3:0] ci_q;
	logic signed [20:0] dx_q, dy_q;
	logic [19:0] dist_q;
	logic [39:0] d2_q;
	logic signed [63:0] p_q;

	logic [63:0] sq_v_q, sq_res_q;
	logic [4:0] sq_k_q;

	logic [40:0] dv_r_q;
	logic [39:0] dv_d_q;
	logic [31:0] dv_n_q, dv_qt_q;
	logic [5:0] dv_cnt_q;
	logic [31:0] q_q;

	logic signed [31:0] sum0_q, sum1_q, dir0_q, dir1_q;
	logic zflag_q, sflag_q;
	logic [31:0] norm_q;
	logic normed_q;
	logic out_valid_q;
	pfs_out_t out_q;

	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		unique case (paddr[3:2])
			REG_CUR0:   prdata = {{16{cur0_q[15]}}, cur0_q};
			REG_CUR1:   prdata = {{16{cur1_q[15]}}, cur1_q};
			REG_THRESH: prdata = {16'd0, thresh_q};
			default:    prdata = 32'd0;
		endcase
	end

	// joint selection
	logic signed [15:0] cur_j, smp_j;
	logic signed [16:0] v_j;
	logic [15:0] mag_j;
	assign cur_j = j_q ? cur1_q : cur0_q;
	assign smp_j = j_q ? smp1_q : smp0_q;
	assign v_j = 17'(smp_j) - 17'(cur_j);
	assign mag_j = v_j[16] ? 16'(-v_j) : 16'(v_j);

	// angle reduction into [-pi/2, pi/2]
	logic signed [21:0] rd_t16, rd_a, rd_m, rd_r, rd_f;
	logic rd_neg;
	always_comb begin
		rd_t16 = 22'({(which_q ? t2_q : t1_q), 4'b0000});
		rd_a = rd_t16[21] ? -rd_t16 : rd_t16;
		if (rd_a >= FOUR_PI_Q16)
			rd_m = rd_a - FOUR_PI_Q16;
		else if (rd_a >= TWO_PI_Q16)
			rd_m = rd_a - TWO_PI_Q16;
		else
			rd_m = rd_a;
		rd_r = rd_t16[21] ? -rd_m : rd_m;
		if (rd_r > PI_Q16)
			rd_r = rd_r - TWO_PI_Q16;
		else if (rd_r < -PI_Q16)
			rd_r = rd_r + TWO_PI_Q16;
		rd_neg = 1'b0;
		rd_f = rd_r;
		if (rd_r > HALF_PI_Q16) begin
			rd_f = rd_r - PI_Q16;
			rd_neg = 1'b1;
		end else if (rd_r < -HALF_PI_Q16) begin
			rd_f = rd_r + PI_Q16;
			rd_neg = 1'b1;
		end
	end

	// cordic step
	logic signed [19:0] cx_n, cy_n, c_out, s_out;
	always_comb begin
		if (!z_q[19]) begin
			cx_n = x_q - (y_q >>> ci_q);
			cy_n = y_q + (x_q >>> ci_q);
		end else begin
			cx_n = x_q + (y_q >>> ci_q);
			cy_n = y_q - (x_q >>> ci_q);
		end
		c_out = neg_q ? -cx_n : cx_n;
		s_out = neg_q ? -cy_n : cy_n;
	end

	// shared multiplier
	logic signed [31:0] mul_a;
	logic signed [63:0] mul_p;
	always_comb begin
		case (state_q)
			S_SQX:   mul_a = 32'(dx_q);
			S_SQY:   mul_a = 32'(dy_q);
			S_D2:    mul_a = {12'd0, dist_q};
			S_SQ0:   mul_a = sum0_q;
			default: mul_a = sum1_q;
		endcase
		mul_p = mul_a * mul_a;
	end

	// isqrt step
	logic [63:0] sq_bit, sq_trial, sq_res_n, sq_v_n;
	always_comb begin
		sq_bit = 64'd1 << {~sq_k_q, 1'b0};
		sq_trial = sq_res_q + sq_bit;
		if (sq_v_q >= sq_trial) begin
			sq_v_n = sq_v_q - sq_trial;
			sq_res_n = (sq_res_q >> 1) + sq_bit;
		end else begin
			sq_v_n = sq_v_q;
			sq_res_n = sq_res_q >> 1;
		end
	end

	// divider step
	logic [40:0] dv_r2, dv_r_n;
	logic dv_bit;
	logic [31:0] dv_qt_n;
	always_comb begin
		dv_r2 = {dv_r_q[39:0], dv_n_q[31]};
		dv_bit = (dv_r2 >= {1'b0, dv_d_q});
		dv_r_n = dv_bit ? dv_r2 - {1'b0, dv_d_q} : dv_r2;
		dv_qt_n = {dv_qt_q[30:0], dv_bit};
	end

	// force accumulate
	logic f_neg, f_sat;
	logic [31:0] f_qc;
	logic signed [32:0] f_v, acc_sum;
	logic signed [31:0] f_c, acc_c;
	logic acc_ovf;
	always_comb begin
		f_neg = v_j[16] != !attr_q;
		f_qc = (q_q[31] && (|q_q[30:0])) ? 32'h8000_0000 : q_q;
		f_v = f_neg ? -$signed({1'b0, f_qc}) : $signed({1'b0, f_qc});
		f_sat = !f_neg && f_qc[31];
		f_c = f_sat ? 32'sh7fff_ffff : f_v[31:0];
		acc_sum = 33'(j_q ? sum1_q : sum0_q) + 33'(f_c);
		acc_ovf = acc_sum[32] != acc_sum[31];
		acc_c = acc_ovf ? (acc_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : acc_sum[31:0];
	end

	logic [31:0] abs0, abs1;
	logic signed [31:0] dir_q;
	logic signed [31:0] dir_sum;
	assign abs0 = sum0_q[31] ? 32'(-sum0_q) : 32'(sum0_q);
	assign abs1 = sum1_q[31] ? 32'(-sum1_q) : 32'(sum1_q);
	assign dir_sum = (div_kind_q == DK_DIR1) ? sum1_q : sum0_q;
	assign dir_q = dir_sum[31] ? -$signed({17'd0, dv_qt_n[14:0]})
		: $signed({17'd0, dv_qt_n[14:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur0_q <= '0;
			cur1_q <= '0;
			thresh_q <= 16'd1;
			sum0_q <= '0;
			sum1_q <= '0;
			zflag_q <= 1'b0;
			sflag_q <= 1'b0;
			out_valid_q <= 1'b0;
			div_kind_q <= DK_FORCE;
			j_q <= 1'b0;
			which_q <= 1'b0;
			sqrt_final_q <= 1'b0;
			ci_q <= '0;
			sq_k_q <= '0;
			dv_cnt_q <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_CUR0:   cur0_q <= pwdata[15:0];
					REG_CUR1:   cur1_q <= pwdata[15:0];
					REG_THRESH: thresh_q <= pwdata[15:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall && state_q != S_OUT)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						smp0_q <= in_data.sample_angle_0;
						smp1_q <= in_data.sample_angle_1;
						attr_q <= in_data.attractive;
						last_q <= in_data.last_sample;
						j_q <= 1'b0;
						t1_q <= '0;
						t2_q <= '0;
						dx_q <= '0;
						dy_q <= '0;
						dist_q <= '0;
						state_q <= S_ANG;
					end
				end
				S_ANG: begin
					t1_q <= t1_q + 18'(cur_j);
					t2_q <= t2_q + 18'(smp_j);
					which_q <= 1'b0;
					state_q <= S_RED;
				end
				S_RED: begin
					x_q <= CORDIC_GAIN;
					y_q <= '0;
					z_q <= rd_f[19:0];
					neg_q <= rd_neg;
					ci_q <= '0;
					state_q <= S_CORD;
				end
				S_CORD: begin
					x_q <= cx_n;
					y_q <= cy_n;
					z_q <= z_q[19] ? z_q + atan_q16(ci_q) : z_q - atan_q16(ci_q);
					ci_q <= ci_q + 4'd1;
					if (ci_q == 4'd15) begin
						if (!which_q) begin
							c1_q <= c_out;
							s1_q <= s_out;
							which_q <= 1'b1;
							state_q <= S_RED;
						end else begin
							dx_q <= dx_q + 21'(c1_q) - 21'(c_out);
							dy_q <= dy_q + 21'(s1_q) - 21'(s_out);
							state_q <= S_SQX;
						end
					end
				end
				S_SQX: begin
					p_q <= mul_p;
					state_q <= S_SQY;
				end
				S_SQY: begin
					sq_v_q <= 64'(p_q + mul_p);
					sq_res_q <= '0;
					sq_k_q <= '0;
					sqrt_final_q <= 1'b0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					sq_v_q <= sq_v_n;
					sq_res_q <= sq_res_n;
					sq_k_q <= sq_k_q + 5'd1;
					if (sq_k_q == 5'd31) begin
						if (sqrt_final_q) begin
							norm_q <= sq_res_n[31:0];
							state_q <= S_NORM;
						end else begin
							dist_q <= dist_q + sq_res_n[19:0];
							if (j_q == 1'(JOINTS - 1)) begin
								state_q <= S_DCHK;
							end else begin
								j_q <= 1'b1;
								state_q <= S_ANG;
							end
						end
					end
				end
				S_DCHK: begin
					j_q <= 1'b0;
					if (dist_q == 20'd0) begin
						zflag_q <= 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_D2;
					end
				end
				S_D2: begin
					d2_q <= mul_p[39:0];
					state_q <= S_FV;
				end
				S_FV: begin
					if ({20'd0, mag_j, 4'b0000} >= d2_q) begin
						q_q <= 32'h8000_0000;
						state_q <= S_ACC;
					end else begin
						dv_r_q <= {21'd0, mag_j, 4'b0000};
						dv_d_q <= d2_q;
						dv_n_q <= '0;
						dv_qt_q <= '0;
						dv_cnt_q <= 6'd32;
						div_kind_q <= DK_FORCE;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					dv_r_q <= dv_r_n;
					dv_n_q <= {dv_n_q[30:0], 1'b0};
					dv_qt_q <= dv_qt_n;
					dv_cnt_q <= dv_cnt_q - 6'd1;
					if (dv_cnt_q == 6'd1) begin
						unique case (div_kind_q)
							DK_FORCE: begin
								q_q <= dv_qt_n;
								state_q <= S_ACC;
							end
							DK_DIR0: begin
								dir0_q <= dir_q;
								dv_r_q <= {10'd0, abs1[31:1]};
								dv_n_q <= {abs1[0], 31'd0};
								dv_qt_q <= '0;
								dv_cnt_q <= 6'd15;
								div_kind_q <= DK_DIR1;
							end
							default: begin
								dir1_q <= dir_q;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_ACC: begin
					if (f_sat || acc_ovf)
						sflag_q <= 1'b1;
					if (j_q)
						sum1_q <= acc_c;
					else
						sum0_q <= acc_c;
					if (j_q == 1'(JOINTS - 1)) begin
						state_q <= S_FIN;
					end else begin
						j_q <= 1'b1;
						state_q <= S_FV;
					end
				end
				S_FIN: begin
					state_q <= last_q ? S_SQ0 : S_IDLE;
				end
				S_SQ0: begin
					p_q <= mul_p;
					state_q <= S_SQ1;
				end
				S_SQ1: begin
					sq_v_q <= 64'(p_q) + 64'(mul_p);
					sq_res_q <= '0;
					sq_k_q <= '0;
					sqrt_final_q <= 1'b1;
					state_q <= S_SQRT;
				end
				S_NORM: begin
					normed_q <= (norm_q != 32'd0) && (norm_q >= {16'd0, thresh_q});
					if ((norm_q != 32'd0) && (norm_q >= {16'd0, thresh_q})) begin
						dv_r_q <= {10'd0, abs0[31:1]};
						dv_d_q <= {8'd0, norm_q};
						dv_n_q <= {abs0[0], 31'd0};
						dv_qt_q <= '0;
						dv_cnt_q <= 6'd15;
						div_kind_q <= DK_DIR0;
						state_q <= S_DIV;
					end else begin
						dir0_q <= sum0_q;
						dir1_q <= sum1_q;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_q.force_magnitude <= norm_q;
						out_q.direction_0 <= dir0_q;
						out_q.direction_1 <= dir1_q;
						out_q.normalized <= normed_q;
						out_q.zero_distance_seen <= zflag_q;
						out_q.saturated <= sflag_q;
						out_valid_q <= 1'b1;
						sum0_q <= '0;
						sum1_q <= '0;
						zflag_q <= 1'b0;
						sflag_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while sequencer busy");
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_OUT))
		else $error("result appeared outside output step");
	a_normed_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.normalized) |-> (out_data.force_magnitude != 32'd0))
		else $error("normalized result with zero magnitude");
	a_cordic_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CORD) |-> (ci_q == 4'd0 || $past(state_q == S_CORD)))
		else $error("cordic counter moved outside cordic step");

endmodule
`default_nettype wire

FILE: test/potential_field_force_sum_top_tb.sv
// self-checking testbench for the potential field force sum block: directed table, random batches
`default_nettype none
module potential_field_force_sum_top_tb import pfs_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int SETTLE_CYCLES = 600;
	localparam int RAND_PER_PHASE = 240;

	typedef struct {
		pfs_in_t  item;
		bit       typed;
		pfs_out_t result;
	} sample_row_t;

	typedef struct packed {
		logic signed [15:0] a0;
		logic signed [15:0] a1;
		logic               att;
		logic               last;
		logic               typed;
	} table_row_t;

	localparam pfs_out_t ZERO_DIST_RESULT = '{force_magnitude: 32'd0, direction_0: 32'sd0,
		direction_1: 32'sd0, normalized: 1'b0, zero_distance_seen: 1'b1, saturated: 1'b0};

	localparam int TABLE_ROWS = 14;
	localparam table_row_t DIRECTED[TABLE_ROWS] = '{
		'{16'sd0, 16'sd0, 1'b1, 1'b1, 1'b1},
		'{16'sd0, 16'sd0, 1'b0, 1'b1, 1'b1},
		'{16'sd32767, 16'sd32767, 1'b1, 1'b1, 1'b0},
		'{-16'sd32768, -16'sd32768, 1'b0, 1'b1, 1'b0},
		'{16'sd32767, -16'sd32768, 1'b1, 1'b0, 1'b0},
		'{-16'sd32768, 16'sd32767, 1'b0, 1'b1, 1'b0},
		'{16'sd1, 16'sd0, 1'b1, 1'b1, 1'b0},
		'{16'sd0, 16'sd1, 1'b0, 1'b0, 1'b0},
		'{16'sd0, -16'sd1, 1'b1, 1'b1, 1'b0},
		'{16'sd16, 16'sd16, 1'b1, 1'b0, 1'b0},
		'{-16'sd16, 16'sd0, 1'b0, 1'b0, 1'b0},
		'{16'sd0, 16'sd0, 1'b1, 1'b1, 1'b0},
		'{16'sd12868, 16'sd0, 1'b1, 1'b1, 1'b0},
		'{-16'sd12868, 16'sd6434, 1'b0, 1'b1, 1'b0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	pfs_in_t     in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	pfs_out_t    out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	potential_field_force_sum_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of registers and batch state
	logic signed [15:0] cur_angle_0 = 16'sd0;
	logic signed [15:0] cur_angle_1 = 16'sd0;
	logic [15:0]        norm_floor = 16'd1;
	longint             acc_0 = 0;
	longint             acc_1 = 0;
	bit                 skipped_flag = 0;
	bit                 clamp_flag = 0;

	sample_row_t pending_samples[$];
	pfs_out_t    expected_forces[$];
	pfs_out_t    typed_forces[$];
	int          sender_idle = 16;
	int          receiver_idle = 71;
	int          hold_off = 0;
	int          fails = 0;
	int          items_sent = 0;
	int          results_seen = 0;
	int          batches_queued = 0;
	int          quiet_cycles = 0;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic void trig_q16(longint t_q12, output longint c, output longint s);
		longint r, x, y, z, xs, ys;
		longint atan_tab[16];
		bit neg;
		atan_tab = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		r = (t_q12 * 16) % 411774;
		x = 39797;
		y = 0;
		neg = 0;
		if (r > 205887)
			r -= 411774;
		else if (r < -205887)
			r += 411774;
		if (r > 102944) begin
			r -= 205887;
			neg = 1;
		end else if (r < -102944) begin
			r += 205887;
			neg = 1;
		end
		z = r;
		for (int i = 0; i < 16; i++) begin
			xs = y >>> i;
			ys = x >>> i;
			if (z >= 0) begin
				x -= xs; y += ys; z -= atan_tab[i];
			end else begin
				x += xs; y -= ys; z += atan_tab[i];
			end
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) begin
			clamp_flag = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			clamp_flag = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// folds one sample into the batch sums; returns 1 with the force result on the last sample
	function automatic bit fold_sample(pfs_in_t smp, output pfs_out_t res);
		longint cur[2], sv[2], t1, t2, dx, dy, c1, s1, c2, s2, v, f, d, sums[2];
		longint unsigned chain_len, d2, q, mag, norm;
		bit normed, negative;
		cur[0] = cur_angle_0;
		cur[1] = cur_angle_1;
		sv[0] = smp.sample_angle_0;
		sv[1] = smp.sample_angle_1;
		t1 = 0; t2 = 0; dx = 0; dy = 0; chain_len = 0;
		res = '0;
		for (int i = 0; i < 2; i++) begin
			t1 += cur[i];
			t2 += sv[i];
			trig_q16(t1, c1, s1);
			trig_q16(t2, c2, s2);
			dx += c1 - c2;
			dy += s1 - s2;
			chain_len += int_sqrt(longint'(dx * dx + dy * dy));
		end
		if (chain_len == 0) begin
			skipped_flag = 1;
		end else begin
			d2 = chain_len * chain_len;
			for (int i = 0; i < 2; i++) begin
				v = sv[i] - cur[i];
				mag = (v < 0) ? -v : v;
				q = (mag << 36) / d2;
				negative = (v < 0) != !smp.attractive;
				if (q > 64'd2147483648)
					q = 64'd2147483648;
				f = negative ? -longint'(q) : longint'(q);
				f = clamp32(f);
				if (i == 0)
					acc_0 = clamp32(acc_0 + f);
				else
					acc_1 = clamp32(acc_1 + f);
			end
		end
		if (!smp.last_sample)
			return 0;
		sums[0] = acc_0;
		sums[1] = acc_1;
		norm = int_sqrt(longint'(sums[0] * sums[0]) + longint'(sums[1] * sums[1]));
		if (norm > 64'hFFFF_FFFF) begin
			norm = 64'hFFFF_FFFF;
			clamp_flag = 1;
		end
		normed = norm != 0 && norm >= norm_floor;
		res.force_magnitude = norm[31:0];
		for (int i = 0; i < 2; i++) begin
			d = sums[i];
			if (normed)
				d = (d * 16384) / longint'(norm);
			if (i == 0)
				res.direction_0 = d[31:0];
			else
				res.direction_1 = d[31:0];
		end
		res.normalized = normed;
		res.zero_distance_seen = skipped_flag;
		res.saturated = clamp_flag;
		acc_0 = 0;
		acc_1 = 0;
		skipped_flag = 0;
		clamp_flag = 0;
		return 1;
	endfunction

	task automatic check_force(pfs_out_t want, pfs_out_t got);
		if (got.force_magnitude !== want.force_magnitude) begin
			$error("force_magnitude expected %0d actual %0d", want.force_magnitude,
				got.force_magnitude);
			fails++;
		end
		if (got.direction_0 !== want.direction_0) begin
			$error("direction_0 expected %0d actual %0d", want.direction_0, got.direction_0);
			fails++;
		end
		if (got.direction_1 !== want.direction_1) begin
			$error("direction_1 expected %0d actual %0d", want.direction_1, got.direction_1);
			fails++;
		end
		if (got.normalized !== want.normalized) begin
			$error("normalized expected %0d actual %0d", want.normalized, got.normalized);
			fails++;
		end
		if (got.zero_distance_seen !== want.zero_distance_seen) begin
			$error("zero_distance_seen expected %0d actual %0d", want.zero_distance_seen,
				got.zero_distance_seen);
			fails++;
		end
		if (got.saturated !== want.saturated) begin
			$error("saturated expected %0d actual %0d", want.saturated, got.saturated);
			fails++;
		end
	endtask

	// input side, predictor and result check share one edge
	always @(posedge clk) begin
		pfs_out_t res, want;
		sample_row_t row;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				row = pending_samples.pop_front();
				items_sent++;
				if (fold_sample(in_data, res)) begin
					expected_forces = {expected_forces, res};
					if (row.typed)
						typed_forces = {typed_forces, row.result};
					else
						typed_forces = {typed_forces, res};
				end
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_forces.size() == 0) begin
					$error("result transfer with no expectation waiting");
					fails++;
				end else begin
					want = expected_forces.pop_front();
					check_force(want, out_data);
					want = typed_forces.pop_front();
					check_force(want, out_data);
				end
			end
			if (!(in_valid && in_stall)) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle) begin
					in_valid <= 1'b1;
					in_data <= pending_samples[0].item;
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (hold_off > 0) begin
				hold_off--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < receiver_idle);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic reg_write(logic [3:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr)
			{REG_CUR0, 2'b00}:   cur_angle_0 = data[15:0];
			{REG_CUR1, 2'b00}:   cur_angle_1 = data[15:0];
			{REG_THRESH, 2'b00}: norm_floor = data[15:0];
			default: ;
		endcase
	endtask

	task automatic set_state(logic [15:0] a0, logic [15:0] a1, logic [15:0] th);
		reg_write({REG_CUR0, 2'b00}, {16'($urandom_range(65535)), a0});
		reg_write({REG_CUR1, 2'b00}, {16'h0, a1});
		reg_write({REG_THRESH, 2'b00}, {16'hFFFF, th});
	endtask

	task automatic queue_sample(logic signed [15:0] a0, logic signed [15:0] a1, bit att,
		bit last);
		sample_row_t row;
		row.item = '{sample_angle_0: a0, sample_angle_1: a1, attractive: att,
			last_sample: last};
		row.typed = 0;
		row.result = '0;
		pending_samples = {pending_samples, row};
	endtask

	task automatic queue_batches(int count);
		int made, len, kind;
		logic signed [15:0] a0, a1;
		made = 0;
		while (made < count) begin
			if ($urandom_range(9) == 0) begin
				queue_sample(16'($urandom), 16'($urandom), 1'($urandom_range(1)),
					1'($urandom_range(1)));
				made++;
			end else begin
				len = ($urandom_range(3) == 0) ? $urandom_range(8, 1) : $urandom_range(3, 1);
				for (int k = 0; k < len; k++) begin
					kind = $urandom_range(99);
					if (kind < 50) begin
						a0 = cur_angle_0 + $signed(16'($urandom_range(128))) - 16'sd64;
						a1 = cur_angle_1 + $signed(16'($urandom_range(128))) - 16'sd64;
					end else if (kind < 62) begin
						a0 = cur_angle_0;
						a1 = cur_angle_1;
					end else begin
						a0 = 16'($urandom);
						a1 = 16'($urandom);
					end
					queue_sample(a0, a1, 1'($urandom_range(1)), k == len - 1);
					made++;
				end
				batches_queued++;
			end
		end
	endtask

	task automatic drain;
		while (pending_samples.size() != 0 || expected_forces.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		sample_row_t row;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < TABLE_ROWS; r++) begin
			row.item = '{sample_angle_0: DIRECTED[r].a0, sample_angle_1: DIRECTED[r].a1,
				attractive: DIRECTED[r].att, last_sample: DIRECTED[r].last};
			row.typed = DIRECTED[r].typed;
			row.result = ZERO_DIST_RESULT;
			pending_samples = {pending_samples, row};
		end
		drain();

		// write to an unmapped address must leave the registers alone
		reg_write(4'd12, 32'hFFFF_FFFF);
		set_state(16'h7FFF, 16'h8000, 16'hFFFF);
		queue_sample(16'sd32767, -16'sd32768, 1'b1, 1'b1);
		queue_sample(16'sd32766, -16'sd32767, 1'b0, 1'b1);
		queue_batches(RAND_PER_PHASE);
		hold_off = 3000;
		drain();

		sender_idle = 71;
		receiver_idle = 16;
		set_state(16'($urandom), 16'($urandom), 16'($urandom_range(4096)));
		queue_batches(RAND_PER_PHASE);
		drain();
		set_state(16'h8000, 16'h7FFF, 16'h0000);
		queue_batches(RAND_PER_PHASE);
		drain();

		sender_idle = 0;
		receiver_idle = 0;
		set_state(16'($urandom), 16'($urandom), 16'($urandom));
		queue_batches(RAND_PER_PHASE);
		drain();
		set_state(16'h0000, 16'h0000, 16'h0001);
		queue_batches(RAND_PER_PHASE);
		drain();

		$display("covered %0d samples in %0d random batches plus the directed table",
			items_sent, batches_queued);
		$display("checked %0d force results over six register settings", results_seen);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire
